### hdl/bto_pkg.sv
`timescale 1ns / 1ps

package bto_pkg;

    // fixed field widths
    localparam int SLOT_W  = 3;
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int EDGE_W  = 18;

    typedef enum logic [1:0] {
        OP_STORE   = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_RESOLVE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STORE,
        S_SCAN,
        S_DRAIN,
        S_FINAL
    } state_t;

    // one table entry, edges plus a flag for nonzero width and height
    typedef struct packed {
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] bottom;
        logic                     solid;
    } box_t;

    // slot pair travelling down the compare pipeline
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] self_id;
        logic [SLOT_W-1:0] other_id;
    } pair_t;

endpackage

### hdl/box_table_pairwise_overlap_unit.sv
`timescale 1ns / 1ps

// channel   signals                                          direction  transfer when
// command   start, busy, op, slot, box_x, box_y, pos_x,      in         start && !busy
//           pos_y, box_width, box_height
// result    result_valid, hit, self_slot, other_slot, last   out        result_valid
//
// store does the position add, then the width and height add with the table write
// remove and ignored commands leave busy low
// resolve walks every slot pair, one slot pair per cycle through the shared compare unit,
//   then drains the 2-stage read/compare pipeline and ends in a final state
// results come out on registered ports, one cycle each, the receiver cannot stall them
// reset clears the valid bits and the sequencer; table contents stay undefined until stored

module box_table_pairwise_overlap_unit
    import bto_pkg::*;
#(
    parameter int MAX_ENTRIES = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 op,
    input  logic [SLOT_W-1:0]          slot,
    input  logic signed [COORD_W-1:0]  box_x,
    input  logic signed [COORD_W-1:0]  box_y,
    input  logic signed [COORD_W-1:0]  pos_x,
    input  logic signed [COORD_W-1:0]  pos_y,
    input  logic [SIZE_W-1:0]          box_width,
    input  logic [SIZE_W-1:0]          box_height,
    output logic                       result_valid,
    output logic                       hit,
    output logic [SLOT_W-1:0]          self_slot,
    output logic [SLOT_W-1:0]          other_slot,
    output logic                       last
);

    localparam int IW = $clog2(MAX_ENTRIES);

    // sequencer state
    state_t state_reg;
    state_t state_next;

    // fsm outputs
    logic accept;
    logic store_go;
    logic remove_go;
    logic resolve_go;
    logic store_wr;
    logic issue_en;
    logic final_emit;
    logic slot_ok;

    // valid bit per slot
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;

    // store holding registers, first add step
    logic signed [EDGE_W-2:0] st_left_reg;
    logic signed [EDGE_W-2:0] st_top_reg;
    logic [SIZE_W-1:0]        st_w_reg;
    logic [SIZE_W-1:0]        st_h_reg;
    logic [IW-1:0]            st_slot_reg;
    box_t                     wr_box;

    // pair counters, a is the outer (self) loop
    logic [IW-1:0] a_reg;
    logic [IW-1:0] a_next;
    logic [IW-1:0] b_reg;
    logic [IW-1:0] b_next;
    logic          scan_done;

    // pipeline: read stage then compare stage
    pair_t issue_pair;
    pair_t rd_pair_reg;
    logic  rd_vld_reg;
    pair_t cmp_pair;
    box_t  box_a;
    box_t  box_b;

    // last hit seen, held back until we know whether it is the final one
    logic              pend_vld_reg;
    logic              pend_vld_next;
    logic [SLOT_W-1:0] pend_self_reg;
    logic [SLOT_W-1:0] pend_self_next;
    logic [SLOT_W-1:0] pend_other_reg;
    logic [SLOT_W-1:0] pend_other_next;

    // result output registers
    logic              res_vld_reg;
    logic              res_vld_next;
    logic              res_hit_reg;
    logic              res_hit_next;
    logic [SLOT_W-1:0] res_self_reg;
    logic [SLOT_W-1:0] res_self_next;
    logic [SLOT_W-1:0] res_other_reg;
    logic [SLOT_W-1:0] res_other_next;
    logic              res_last_reg;
    logic              res_last_next;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign slot_ok = ({1'b0, slot} < (SLOT_W + 1)'(MAX_ENTRIES));

    always_comb
    begin
        store_go   = 1'b0;
        remove_go  = 1'b0;
        resolve_go = 1'b0;
        if (accept)
        begin
            case (op)
                OP_STORE:   store_go   = slot_ok;
                OP_REMOVE:  remove_go  = slot_ok;
                OP_RESOLVE: resolve_go = 1'b1;
                default:    ;
            endcase
        end
    end

    // last pair of the walk
    assign scan_done = (a_reg == IW'(MAX_ENTRIES - 1)) && (b_reg == IW'(MAX_ENTRIES - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (store_go)
                begin
                    state_next = S_STORE;
                end
                else if (resolve_go)
                begin
                    state_next = S_SCAN;
                end
            end
            S_STORE:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // compare stage finishes the last pair in this cycle
                if (!rd_vld_reg)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        store_wr   = 1'b0;
        issue_en   = 1'b0;
        final_emit = 1'b0;
        case (state_reg)
            S_STORE: store_wr   = 1'b1;
            S_SCAN:  issue_en   = 1'b1;
            S_FINAL: final_emit = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // valid bits: set on the table write, cleared on remove
    always_comb
    begin
        valid_next = valid_reg;
        if (store_wr)
        begin
            valid_next[st_slot_reg] = 1'b1;
        end
        if (remove_go)
        begin
            valid_next[slot[IW-1:0]] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // store, step one: left and top from position plus offset
    always_ff @(posedge clk)
    begin
        if (store_go)
        begin
            st_left_reg <= {pos_x[COORD_W-1], pos_x} + {box_x[COORD_W-1], box_x};
            st_top_reg  <= {pos_y[COORD_W-1], pos_y} + {box_y[COORD_W-1], box_y};
            st_w_reg    <= box_width;
            st_h_reg    <= box_height;
            st_slot_reg <= slot[IW-1:0];
        end
    end

    // store, step two: right and bottom, sums always fit the edge width
    always_comb
    begin
        wr_box.left   = {st_left_reg[EDGE_W-2], st_left_reg};
        wr_box.top    = {st_top_reg[EDGE_W-2], st_top_reg};
        wr_box.right  = wr_box.left + {{(EDGE_W - SIZE_W){1'b0}}, st_w_reg};
        wr_box.bottom = wr_box.top + {{(EDGE_W - SIZE_W){1'b0}}, st_h_reg};
        wr_box.solid  = (st_w_reg != '0) && (st_h_reg != '0);
    end

    // pair walk, inner loop on b
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        if (resolve_go)
        begin
            a_next = '0;
            b_next = '0;
        end
        else if (issue_en)
        begin
            if (b_reg == IW'(MAX_ENTRIES - 1))
            begin
                b_next = '0;
                a_next = a_reg + IW'(1);
            end
            else
            begin
                b_next = b_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    // pair qualifies while the walk runs, both slots hold boxes and they differ
    always_comb
    begin
        issue_pair.hit      = issue_en && valid_reg[a_reg] && valid_reg[b_reg] &&
                              (a_reg != b_reg);
        issue_pair.self_id  = SLOT_W'(a_reg);
        issue_pair.other_id = SLOT_W'(b_reg);
    end

    // read stage tag, lines up with the registered table read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            rd_pair_reg <= '0;
        end
        else
        begin
            rd_vld_reg  <= issue_en;
            rd_pair_reg <= issue_pair;
        end
    end

    bto_table #(
        .DEPTH (MAX_ENTRIES),
        .IW    (IW)
    ) u_table (
        .clk       (clk),
        .wr_en     (store_wr),
        .wr_addr   (st_slot_reg),
        .wr_data   (wr_box),
        .rd_addr_a (a_reg),
        .rd_addr_b (b_reg),
        .rd_data_a (box_a),
        .rd_data_b (box_b)
    );

    // shared compare unit, one pair per cycle
    bto_overlap u_overlap (
        .clk      (clk),
        .rst_n    (rst_n),
        .pair_in  (rd_pair_reg),
        .box_a    (box_a),
        .box_b    (box_b),
        .pair_out (cmp_pair)
    );

    // result stage: a new hit releases the one held before it, the final cycle
    // releases the held hit marked last, or the empty result when nothing hit
    always_comb
    begin
        pend_vld_next   = pend_vld_reg;
        pend_self_next  = pend_self_reg;
        pend_other_next = pend_other_reg;
        res_vld_next    = 1'b0;
        res_hit_next    = res_hit_reg;
        res_self_next   = res_self_reg;
        res_other_next  = res_other_reg;
        res_last_next   = res_last_reg;
        if (cmp_pair.hit)
        begin
            if (pend_vld_reg)
            begin
                res_vld_next   = 1'b1;
                res_hit_next   = 1'b1;
                res_self_next  = pend_self_reg;
                res_other_next = pend_other_reg;
                res_last_next  = 1'b0;
            end
            pend_vld_next   = 1'b1;
            pend_self_next  = cmp_pair.self_id;
            pend_other_next = cmp_pair.other_id;
        end
        if (final_emit)
        begin
            res_vld_next   = 1'b1;
            res_last_next  = 1'b1;
            res_hit_next   = pend_vld_reg;
            res_self_next  = pend_vld_reg ? pend_self_reg : '0;
            res_other_next = pend_vld_reg ? pend_other_reg : '0;
            pend_vld_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            pend_vld_reg <= pend_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_self_reg  <= pend_self_next;
        pend_other_reg <= pend_other_next;
        res_hit_reg    <= res_hit_next;
        res_self_reg   <= res_self_next;
        res_other_reg  <= res_other_next;
        res_last_reg   <= res_last_next;
    end

    assign result_valid = res_vld_reg;
    assign hit          = res_hit_reg;
    assign self_slot    = res_self_reg;
    assign other_slot   = res_other_reg;
    assign last         = res_last_reg;

endmodule

### hdl/bto_table.sv
`timescale 1ns / 1ps

module bto_table
    import bto_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int IW    = 3
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  box_t          wr_data,
    input  logic [IW-1:0] rd_addr_a,
    input  logic [IW-1:0] rd_addr_b,
    output box_t          rd_data_a,
    output box_t          rd_data_b
);

    box_t mem [DEPTH];
    box_t rd_a_reg;
    box_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // two registered read ports
    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

### hdl/bto_overlap.sv
`timescale 1ns / 1ps

module bto_overlap
    import bto_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  pair_t pair_in,
    input  box_t  box_a,
    input  box_t  box_b,
    output pair_t pair_out
);

    pair_t pair_reg;
    pair_t pair_next;
    logic  overlap;

    // strict overlap on both axes, empty boxes never overlap
    assign overlap = box_a.solid && box_b.solid &&
                     (box_a.left < box_b.right) && (box_b.left < box_a.right) &&
                     (box_a.top < box_b.bottom) && (box_b.top < box_a.bottom);

    always_comb
    begin
        pair_next     = pair_in;
        pair_next.hit = pair_in.hit && overlap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg <= '0;
        end
        else
        begin
            pair_reg <= pair_next;
        end
    end

    assign pair_out = pair_reg;

endmodule

### tb/box_table_pairwise_overlap_unit_tb.sv
`timescale 1ns / 1ps

module box_table_pairwise_overlap_unit_tb
    import bto_pkg::*;
();

    localparam int NUM_SLOTS      = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    // leave room after a resolve for the last results to come out
    localparam int TAIL_CYCLES    = 100;
    localparam int PHASE_ITEMS    = 76;

    // op code that the block has to ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one command transfer plus how the driver should pace it
    typedef struct {
        logic [1:0]                op;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] box_x;
        logic signed [COORD_W-1:0] box_y;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [SIZE_W-1:0]         box_width;
        logic [SIZE_W-1:0]         box_height;
        int                        idle_pct;
        bit                        drain_first;
    } box_cmd_t;

    // one overlap report as it should appear on the result ports
    typedef struct {
        logic              hit;
        logic [SLOT_W-1:0] self_id;
        logic [SLOT_W-1:0] other_id;
        logic              last;
    } overlap_rpt_t;

    logic                      clk;
    logic                      rst_n        = 1'b0;
    logic                      start        = 1'b0;
    logic                      busy;
    logic [1:0]                op           = OP_STORE;
    logic [SLOT_W-1:0]         slot         = '0;
    logic signed [COORD_W-1:0] box_x        = '0;
    logic signed [COORD_W-1:0] box_y        = '0;
    logic signed [COORD_W-1:0] pos_x        = '0;
    logic signed [COORD_W-1:0] pos_y        = '0;
    logic [SIZE_W-1:0]         box_width    = '0;
    logic [SIZE_W-1:0]         box_height   = '0;
    logic                      result_valid;
    logic                      hit;
    logic [SLOT_W-1:0]         self_slot;
    logic [SLOT_W-1:0]         other_slot;
    logic                      last;

    // commands waiting for the driver, and reports the block still owes us
    box_cmd_t     cmd_backlog[$];
    overlap_rpt_t overlap_rpts_due[$];
    box_cmd_t     held_cmd;

    // shadow box table
    logic                     shadow_live[NUM_SLOTS];
    logic                     shadow_solid[NUM_SLOTS];
    logic signed [EDGE_W-1:0] shadow_left[NUM_SLOTS];
    logic signed [EDGE_W-1:0] shadow_top[NUM_SLOTS];
    logic signed [EDGE_W-1:0] shadow_right[NUM_SLOTS];
    logic signed [EDGE_W-1:0] shadow_bottom[NUM_SLOTS];

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // pacing applied to commands as they are queued
    int fill_idle_pct   = 0;
    bit fill_drain_next = 1'b0;

    // current cluster center for the random groups
    int grp_cx = 0;
    int grp_cy = 0;

    box_table_pairwise_overlap_unit #(
        .MAX_ENTRIES (NUM_SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .slot         (slot),
        .box_x        (box_x),
        .box_y        (box_y),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .box_width    (box_width),
        .box_height   (box_height),
        .result_valid (result_valid),
        .hit          (hit),
        .self_slot    (self_slot),
        .other_slot   (other_slot),
        .last         (last)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // shadow table update for one accepted command, queues the reports it causes
    task automatic predict_box_cmd(input box_cmd_t c);
        logic signed [EDGE_W-1:0] l;
        logic signed [EDGE_W-1:0] t;
        overlap_rpt_t             rpt;
        int                       n_hits;
        n_hits = 0;
        case (c.op)
            OP_STORE:
            begin
                // 16-bit signed sums sign extend into the 18-bit edges
                l = $signed(c.pos_x) + $signed(c.box_x);
                t = $signed(c.pos_y) + $signed(c.box_y);
                shadow_left[c.slot]   = l;
                shadow_top[c.slot]    = t;
                shadow_right[c.slot]  = l + $signed({1'b0, c.box_width});
                shadow_bottom[c.slot] = t + $signed({1'b0, c.box_height});
                shadow_solid[c.slot]  = (c.box_width != '0) && (c.box_height != '0);
                shadow_live[c.slot]   = 1'b1;
            end
            OP_REMOVE:
            begin
                shadow_live[c.slot] = 1'b0;
            end
            OP_RESOLVE:
            begin
                // self outer, other inner, both ascending, strict overlap only
                for (int a = 0; a < NUM_SLOTS; a++)
                begin
                    for (int b = 0; b < NUM_SLOTS; b++)
                    begin
                        if (a != b && shadow_live[a] && shadow_live[b] &&
                            shadow_solid[a] && shadow_solid[b] &&
                            shadow_left[a] < shadow_right[b] &&
                            shadow_left[b] < shadow_right[a] &&
                            shadow_top[a] < shadow_bottom[b] &&
                            shadow_top[b] < shadow_bottom[a])
                        begin
                            rpt.hit      = 1'b1;
                            rpt.self_id  = SLOT_W'(a);
                            rpt.other_id = SLOT_W'(b);
                            rpt.last     = 1'b0;
                            overlap_rpts_due.push_back(rpt);
                            n_hits++;
                        end
                    end
                end
                if (n_hits == 0)
                begin
                    // nothing overlaps: a single empty report closes the resolve
                    rpt.hit      = 1'b0;
                    rpt.self_id  = '0;
                    rpt.other_id = '0;
                    rpt.last     = 1'b1;
                    overlap_rpts_due.push_back(rpt);
                end
                else
                begin
                    overlap_rpts_due[overlap_rpts_due.size() - 1].last = 1'b1;
                end
            end
            default:
            begin
                // unused op code, the table stays as it is
            end
        endcase
    endtask

    function automatic void queue_box_cmd(logic [1:0] op_code, int s, int bx, int by,
                                          int px, int py, int w, int h);
        box_cmd_t c;
        c.op          = op_code;
        c.slot        = SLOT_W'(s);
        c.box_x       = COORD_W'(bx);
        c.box_y       = COORD_W'(by);
        c.pos_x       = COORD_W'(px);
        c.pos_y       = COORD_W'(py);
        c.box_width   = SIZE_W'(w);
        c.box_height  = SIZE_W'(h);
        c.idle_pct    = fill_idle_pct;
        c.drain_first = fill_drain_next;
        fill_drain_next = 1'b0;
        cmd_backlog.push_back(c);
    endfunction

    // a burst of stores and removes with random content, usually closed by a resolve;
    // returns how many commands count as real work
    function automatic int queue_random_group();
        int n_ops;
        int counted;
        int mode;
        int sz_w;
        int sz_h;
        counted = 0;
        n_ops   = $urandom_range(1, 7);
        if ($urandom_range(0, 1) == 0)
        begin
            grp_cx = int'($urandom_range(0, 40000)) - 20000;
            grp_cy = int'($urandom_range(0, 40000)) - 20000;
        end
        for (int i = 0; i < n_ops; i++)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                // noise: an op code the block has to drop
                queue_box_cmd(OP_UNUSED, $urandom_range(0, 7), $urandom(), $urandom(),
                              $urandom(), $urandom(), $urandom(), $urandom());
            end
            else if ($urandom_range(0, 99) < 25)
            begin
                queue_box_cmd(OP_REMOVE, $urandom_range(0, 7), 0, 0, 0, 0, 0, 0);
                counted++;
            end
            else
            begin
                mode = $urandom_range(0, 9);
                if (mode == 0)
                begin
                    // every field at random over its whole range
                    queue_box_cmd(OP_STORE, $urandom_range(0, 7), $urandom(), $urandom(),
                                  $urandom(), $urandom(), $urandom(), $urandom());
                end
                else
                begin
                    sz_w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 400);
                    sz_h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 400);
                    if (mode == 1)
                    begin
                        // huge box that covers most of its neighbors
                        sz_w = 32767;
                        sz_h = $urandom_range(16384, 32767);
                    end
                    queue_box_cmd(OP_STORE, $urandom_range(0, 7),
                                  int'($urandom_range(0, 600)) - 300,
                                  int'($urandom_range(0, 600)) - 300,
                                  grp_cx + int'($urandom_range(0, 200)) - 100,
                                  grp_cy + int'($urandom_range(0, 200)) - 100,
                                  sz_w, sz_h);
                end
                counted++;
            end
        end
        if ($urandom_range(0, 9) != 0)
        begin
            queue_box_cmd(OP_RESOLVE, $urandom_range(0, 7), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom(), $urandom());
            counted++;
        end
        return counted;
    endfunction

    function automatic void check_field(string fname, logic [3:0] want, logic [3:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            mismatch_count++;
        end
    endfunction

    // command driver: holds an item until busy is low, then predicts it and moves on
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_box_cmd(held_cmd);
            end
            if (!start || !busy)
            begin
                // drain_first holds the next item until the block owes nothing
                if (cmd_backlog.size() != 0 &&
                    !(cmd_backlog[0].drain_first && overlap_rpts_due.size() != 0) &&
                    $urandom_range(0, 99) >= cmd_backlog[0].idle_pct)
                begin
                    held_cmd    = cmd_backlog.pop_front();
                    start      <= 1'b1;
                    op         <= held_cmd.op;
                    slot       <= held_cmd.slot;
                    box_x      <= held_cmd.box_x;
                    box_y      <= held_cmd.box_y;
                    pos_x      <= held_cmd.pos_x;
                    pos_y      <= held_cmd.pos_y;
                    box_width  <= held_cmd.box_width;
                    box_height <= held_cmd.box_height;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor: every strobe has to match the oldest owed report
    always @(posedge clk)
    begin : result_check
        overlap_rpt_t want;
        if (rst_n && result_valid)
        begin
            if (overlap_rpts_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, %s %0d self %0d other %0d last %0d",
                         $time, "actual hit", hit, self_slot, other_slot, last);
                mismatch_count++;
            end
            else
            begin
                want = overlap_rpts_due.pop_front();
                check_field("hit", want.hit, hit);
                check_field("self_slot", want.self_id, self_slot);
                check_field("other_slot", want.other_id, other_slot);
                check_field("last", want.last, last);
            end
        end
    end

    // watchdog: too long without a command transfer or a result ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: timeout, nothing transferred for %0d cycles",
                             $time, quiet_cycles);
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        int phase_count;
        int idle_by_phase[4];
        idle_by_phase = '{0, 61, 0, 32};
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            shadow_live[i] = 1'b0;
        end

        // directed: resolve on an empty table gives one empty report
        queue_box_cmd(OP_RESOLVE, 0, 0, 0, 0, 0, 0, 0);
        // coordinate extremes, far apart from each other
        queue_box_cmd(OP_STORE, 0, 32767, 32767, 32767, 32767, 32767, 32767);
        queue_box_cmd(OP_STORE, 7, -32768, -32768, -32768, -32768, 32767, 32767);
        // zero width and zero height boxes on top of a real one never overlap
        queue_box_cmd(OP_STORE, 1, 0, 0, 0, 0, 0, 100);
        queue_box_cmd(OP_STORE, 2, -20, -20, 10, 10, 50, 50);
        queue_box_cmd(OP_STORE, 3, 0, 0, 0, 0, 100, 0);
        queue_box_cmd(OP_RESOLVE, 0, 0, 0, 0, 0, 0, 0);
        // touching edges do not count, a real overlap reports both directions
        queue_box_cmd(OP_STORE, 4, 0, 0, 100, 0, 50, 50);
        queue_box_cmd(OP_STORE, 5, 0, 0, 150, 0, 50, 50);
        queue_box_cmd(OP_STORE, 6, -5, -5, 160, 20, 20, 20);
        queue_box_cmd(OP_RESOLVE, 0, 0, 0, 0, 0, 0, 0);
        // remove, ignored op code, overwrite of a used slot
        queue_box_cmd(OP_REMOVE, 5, 0, 0, 0, 0, 0, 0);
        queue_box_cmd(OP_UNUSED, 5, -1, -1, -1, -1, 32767, 32767);
        queue_box_cmd(OP_STORE, 6, 0, 0, 0, 0, 30, 30);
        queue_box_cmd(OP_RESOLVE, 0, 0, 0, 0, 0, 0, 0);
        // full table, every pair overlaps: the most reports from one resolve
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            queue_box_cmd(OP_STORE, s, 500, 500, -1000, -1000, 1000, 1000);
        end
        queue_box_cmd(OP_RESOLVE, 0, 0, 0, 0, 0, 0, 0);

        // random phases with different sender pacing
        for (int ph = 0; ph < 4; ph++)
        begin
            fill_idle_pct   = idle_by_phase[ph];
            fill_drain_next = 1'b1;
            phase_count     = 0;
            while (phase_count < PHASE_ITEMS)
            begin
                phase_count += queue_random_group();
            end
        end

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the last command transfer, then for the owed reports
        @(posedge clk);
        while (cmd_backlog.size() != 0 || start)
        begin
            @(posedge clk);
        end
        while (overlap_rpts_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
